// ===== design/frq_pkg.sv =====
// ----------------------------------------------------------------------------
// frq_pkg
// Shared types and constants of the quarter-turn frame rotation engine:
// register indexes, rotation codes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package frq_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd2;

    // Clockwise rotation codes.
    typedef enum logic [1:0] {
        ROT_NONE = 2'd0,
        ROT_90   = 2'd1,
        ROT_180  = 2'd2,
        ROT_270  = 2'd3
    } rot_mode_t;

    // Request kinds carried by req_type.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE    = 2'd0,
        S_FETCH   = 2'd1,
        S_DELIVER = 2'd2
    } frq_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // an input beat is taken this cycle
        logic fetch;    // read the frame store at the held address
        logic deliver;  // load the output register
    } frq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_is_read;  // the offered beat is a read request
        logic frame_full;   // the frame is completely loaded
        logic out_free;     // the output register can take a beat
    } frq_status_t;

endpackage

// ===== design/frq_ctrl.sv =====
// ----------------------------------------------------------------------------
// frq_ctrl
// Controller of the rotation engine. Takes one request at a time, steps a
// read through the frame store fetch and hands the result to the output
// register once that register is free.
// ----------------------------------------------------------------------------
module frq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  frq_pkg::frq_status_t status,
    output frq_pkg::frq_cmd_t    cmd
);
    import frq_pkg::*;

    frq_state_t state_reg;
    frq_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state. A read of a loaded frame fetches first; a read before the
    // frame is loaded goes straight to delivery; a write needs no result.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && status.req_is_read)
                begin
                    state_next = status.frame_full ? S_FETCH : S_DELIVER;
                end
            end
            S_FETCH:
            begin
                state_next = S_DELIVER;
            end
            S_DELIVER:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready    = 1'b0;
        cmd.accept  = 1'b0;
        cmd.fetch   = 1'b0;
        cmd.deliver = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            S_FETCH:
            begin
                cmd.fetch = 1'b1;
            end
            S_DELIVER:
            begin
                cmd.deliver = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // A fetch is always followed by the delivery of its pixel.
    a_fetch_then_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |=> (state_reg == S_DELIVER))
        else $error("fetch not followed by delivery");

    // An accepted read always leaves the idle state to produce its result.
    a_read_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && status.req_is_read) |=> (state_reg != S_IDLE))
        else $error("accepted read produced no result");

    // At most one datapath command in any cycle.
    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.fetch, cmd.deliver}))
        else $error("overlapping datapath commands");
`endif

endmodule

// ===== design/frq_datapath.sv =====
// ----------------------------------------------------------------------------
// frq_datapath
// Datapath of the rotation engine: configuration registers, load counter,
// output position counters, source address generation, the frame store
// memory and the output register.
// ----------------------------------------------------------------------------
module frq_datapath #(
    parameter int MAX_DIM    = 64,
    parameter int PIXEL_BITS = 24,
    parameter int DIM_W      = $clog2(MAX_DIM + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [frq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]         cfg_data,
    input  logic                     req_type,
    input  logic [PIXEL_BITS-1:0]    pixel_in,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic [PIXEL_BITS-1:0]    pixel_out,
    output logic                     last_pixel,
    output logic                     read_status,
    input  frq_pkg::frq_cmd_t        cmd,
    output frq_pkg::frq_status_t     status
);
    import frq_pkg::*;

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int STORE  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(STORE);
    localparam int CNT_W  = $clog2(STORE + 1);
    localparam int PROD_W = ADDR_W + DIM_W;

    // Configuration registers.
    rot_mode_t        mode_reg;
    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] width_reg;

    // Frame and position state.
    logic [CNT_W-1:0] load_count_reg, load_count_next;
    logic [IDX_W-1:0] out_row_reg, out_row_next;
    logic [IDX_W-1:0] out_col_reg, out_col_next;
    logic             full_reg, full_next;

    // Per-request registers.
    logic [ADDR_W-1:0]     sr_reg, sr_next;
    logic [ADDR_W-1:0]     sc_reg, sc_next;
    logic                  last_reg;
    logic                  not_ready_reg;
    logic [PIXEL_BITS-1:0] mem_q_reg;

    // Output register.
    logic                  out_valid_reg;
    logic [PIXEL_BITS-1:0] pixel_out_reg;
    logic                  last_pixel_reg;
    logic                  read_status_reg;

    // Frame store.
    logic [PIXEL_BITS-1:0] frame_store_mem [STORE];

    logic [DIM_W-1:0]   h_c, w_c, oh, ow;
    logic [DIM_W-1:0]   row_d, col_d, row_p1, col_p1;
    logic [2*DIM_W-1:0] total_full;
    logic [CNT_W-1:0]   total;
    logic               last_hit, wrap;
    logic               wr_en;
    logic [ADDR_W-1:0]  row_a, col_a, hm1, wm1;
    logic [PROD_W-1:0]  prod;
    logic [ADDR_W-1:0]  addr_sum;
    logic [ADDR_W-1:0]  rd_addr;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= ROT_NONE;
            height_reg <= DIM_W'(MAX_DIM);
            width_reg  <= DIM_W'(MAX_DIM);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROTATION_MODE: mode_reg   <= rot_mode_t'(cfg_data[1:0]);
                CFG_IMAGE_HEIGHT:  height_reg <= cfg_data;
                CFG_IMAGE_WIDTH:   width_reg  <= cfg_data;
                default:           mode_reg   <= mode_reg;
            endcase
        end
    end

    // Geometry clamped to 1..MAX_DIM, and the rotated grid.
    always_comb
    begin
        if (height_reg == '0)
            h_c = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_DIM))
            h_c = DIM_W'(MAX_DIM);
        else
            h_c = height_reg;

        if (width_reg == '0)
            w_c = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_DIM))
            w_c = DIM_W'(MAX_DIM);
        else
            w_c = width_reg;

        if (mode_reg == ROT_90 || mode_reg == ROT_270)
        begin
            oh = w_c;
            ow = h_c;
        end
        else
        begin
            oh = h_c;
            ow = w_c;
        end
    end

    assign total_full = h_c * w_c;
    assign total      = CNT_W'(total_full);

    // Position compare: the end of the rotated grid, or a position past it.
    assign row_d    = DIM_W'(out_row_reg);
    assign col_d    = DIM_W'(out_col_reg);
    assign row_p1   = row_d + DIM_W'(1);
    assign col_p1   = col_d + DIM_W'(1);
    assign last_hit = (row_p1 >= oh) && (col_p1 >= ow);
    assign wrap     = last_hit || (row_d >= oh);

    // Source row and column of the current output position, kept modulo
    // the store size.
    assign row_a = ADDR_W'(out_row_reg);
    assign col_a = ADDR_W'(out_col_reg);
    assign hm1   = ADDR_W'(h_c) - ADDR_W'(1);
    assign wm1   = ADDR_W'(w_c) - ADDR_W'(1);

    always_comb
    begin
        case (mode_reg)
            ROT_90:
            begin
                sr_next = hm1 - col_a;
                sc_next = row_a;
            end
            ROT_180:
            begin
                sr_next = hm1 - row_a;
                sc_next = wm1 - col_a;
            end
            ROT_270:
            begin
                sr_next = col_a;
                sc_next = wm1 - row_a;
            end
            default:
            begin
                sr_next = row_a;
                sc_next = col_a;
            end
        endcase
    end

    // Frame state update on an accepted beat.
    assign wr_en = cmd.accept && (req_type == REQ_WRITE) && !full_reg
                   && (load_count_reg < total);

    always_comb
    begin
        load_count_next = load_count_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        full_next       = full_reg;
        if (cmd.accept)
        begin
            if (req_type == REQ_WRITE)
            begin
                if (wr_en)
                    load_count_next = load_count_reg + CNT_W'(1);
                if (load_count_next >= total)
                    full_next = 1'b1;
            end
            else if (full_reg)
            begin
                if (wrap)
                begin
                    load_count_next = '0;
                    out_row_next    = '0;
                    out_col_next    = '0;
                    full_next       = 1'b0;
                end
                else if (col_p1 >= ow)
                begin
                    out_col_next = '0;
                    out_row_next = IDX_W'(row_p1);
                end
                else
                begin
                    out_col_next = IDX_W'(col_p1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= '0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            full_reg       <= 1'b0;
        end
        else
        begin
            load_count_reg <= load_count_next;
            out_row_reg    <= out_row_next;
            out_col_reg    <= out_col_next;
            full_reg       <= full_next;
        end
    end

    // Per-request payload held for the fetch and the delivery.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sr_reg        <= sr_next;
            sc_reg        <= sc_next;
            last_reg      <= wrap;
            not_ready_reg <= !full_reg;
        end
    end

    // Store address: row times width plus column, folded into the store.
    assign prod     = sr_reg * w_c;
    assign addr_sum = ADDR_W'(prod) + sc_reg;
    assign rd_addr  = ({1'b0, addr_sum} >= (ADDR_W + 1)'(STORE))
                      ? ADDR_W'({1'b0, addr_sum} - (ADDR_W + 1)'(STORE))
                      : addr_sum;

    // Frame store: one write port for loading, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            frame_store_mem[load_count_reg[ADDR_W-1:0]] <= pixel_in;
        if (cmd.fetch)
            mem_q_reg <= frame_store_mem[rd_addr];
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.deliver)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.deliver)
        begin
            pixel_out_reg   <= not_ready_reg ? '0 : mem_q_reg;
            last_pixel_reg  <= !not_ready_reg && last_reg;
            read_status_reg <= not_ready_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_out   = pixel_out_reg;
    assign last_pixel  = last_pixel_reg;
    assign read_status = read_status_reg;

    assign status.req_is_read = (req_type == REQ_READ);
    assign status.frame_full  = full_reg;
    assign status.out_free    = !out_valid_reg || out_ready;

`ifndef ASSERT_OFF
    // The load counter never runs past the store size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load_count_reg <= CNT_W'(STORE))
        else $error("load counter past store size");

    // Reading the last pixel rearms the engine for a new frame.
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && req_type == REQ_READ && full_reg && wrap)
        |=> (!full_reg && load_count_reg == '0))
        else $error("engine not rearmed after last pixel");

    // A not-ready read delivers a zero pixel with the not-ready status.
    a_not_ready_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.deliver && not_ready_reg)
        |=> (out_valid_reg && read_status_reg && pixel_out_reg == '0
             && !last_pixel_reg))
        else $error("not-ready read delivered wrong beat");
`endif

endmodule

// ===== design/frame_rotate_quarter_turns.sv =====
// ----------------------------------------------------------------------------
// frame_rotate_quarter_turns
// Quarter-turn frame rotation engine: loads a frame in raster order and
// returns it rotated clockwise by 0, 90, 180 or 270 degrees.
// ----------------------------------------------------------------------------
// Writes are taken one per cycle while no read is in progress, and produce
// no beat. A read of a loaded frame steps through accept, frame store
// fetch and output load; the output load waits for a free output register.
// A read before the frame is loaded skips the fetch: accept, output load.
// No new request is taken until a read's beat is in the output register.
// Reset clears control and configuration at once; the store is not cleared.
module frame_rotate_quarter_turns #(
    parameter int MAX_DIM    = 64,
    parameter int PIXEL_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [frq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [$clog2(MAX_DIM+1)-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          req_type,
    input  logic [PIXEL_BITS-1:0]         pixel_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [PIXEL_BITS-1:0]         pixel_out,
    output logic                          last_pixel,
    output logic                          read_status
);
    import frq_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    frq_cmd_t    cmd;
    frq_status_t status;

    // Controller.
    frq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    frq_datapath #(
        .MAX_DIM    (MAX_DIM),
        .PIXEL_BITS (PIXEL_BITS),
        .DIM_W      (DIM_W)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_type    (req_type),
        .pixel_in    (pixel_in),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .pixel_out   (pixel_out),
        .last_pixel  (last_pixel),
        .read_status (read_status),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// ===== bench/rotation_board_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotation_board_pkg
// Scoreboard for the quarter-turn frame rotation engine. It keeps its own copy
// of the frame store, load counter, read position and registers. From these
// it works out each read beat the engine owes, queues it, and checks the beats
// the engine delivers against that queue in order.
// ----------------------------------------------------------------------------
package rotation_board_pkg;
    import frq_pkg::*;

    localparam int DIM_LIMIT   = 64;
    localparam int STORE_DEPTH = DIM_LIMIT * DIM_LIMIT;

    // One beat on the output channel.
    typedef struct packed {
        logic [23:0] pixel;
        logic        last;
        logic        not_ready;
    } rotated_beat_t;

    class rotation_board;
        // Frame state.
        logic [23:0]   store [STORE_DEPTH];
        logic [12:0]   load_count;
        logic [5:0]    out_row;
        logic [5:0]    out_col;
        bit            full;
        // Register copies.
        rot_mode_t     mode;
        logic [6:0]    height;
        logic [6:0]    width;
        // Beats the engine still owes, oldest first.
        rotated_beat_t owed [$];
        int            checked;
        int            errors;

        function new();
            load_count = '0;
            out_row    = '0;
            out_col    = '0;
            full       = 1'b0;
            mode       = ROT_NONE;
            height     = 7'd64;
            width      = 7'd64;
            checked    = 0;
            errors     = 0;
        endfunction

        // A copy of the frame state and registers, for looking ahead.
        function rotation_board clone();
            rotation_board twin;
            twin            = new();
            twin.store      = store;
            twin.load_count = load_count;
            twin.out_row    = out_row;
            twin.out_col    = out_col;
            twin.full       = full;
            twin.mode       = mode;
            twin.height     = height;
            twin.width      = width;
            return twin;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] index, input logic [6:0] value);
            case (index)
                CFG_ROTATION_MODE: mode = rot_mode_t'(value[1:0]);
                CFG_IMAGE_HEIGHT:  height = value;
                CFG_IMAGE_WIDTH:   width = value;
                default: ;
            endcase
        endfunction

        // A geometry code of zero means one; anything past the limit means the limit.
        function int unsigned span(input logic [6:0] value);
            if (value == 7'd0)
                return 1;
            if (value > DIM_LIMIT)
                return DIM_LIMIT;
            return value;
        endfunction

        // Applies one request to the frame state and returns the beat it causes.
        function void advance(input logic kind, input logic [23:0] pix,
                              output bit produced, output rotated_beat_t beat);
            int unsigned h, w, total, oh, ow, sr, sc, addr, next_col;
            bit fin;
            h        = span(height);
            w        = span(width);
            total    = h * w;
            produced = 1'b0;
            beat     = '0;

            // Writes fill the store in raster order until the frame is complete.
            if (kind == REQ_WRITE) begin
                if (!full && load_count < total) begin
                    store[load_count] = pix;
                    load_count++;
                end
                if (load_count >= total)
                    full = 1'b1;
                return;
            end

            produced = 1'b1;
            if (!full) begin
                beat.not_ready = 1'b1;
                return;
            end

            // Quarter turns swap the output grid's rows and columns.
            if (mode == ROT_90 || mode == ROT_270) begin
                oh = w;
                ow = h;
            end
            else begin
                oh = h;
                ow = w;
            end

            // Map the output position back to the source pixel.
            case (mode)
                ROT_90: begin
                    sr = h - 1 - out_col;
                    sc = out_row;
                end
                ROT_180: begin
                    sr = h - 1 - out_row;
                    sc = w - 1 - out_col;
                end
                ROT_270: begin
                    sr = out_col;
                    sc = w - 1 - out_row;
                end
                default: begin
                    sr = out_row;
                    sc = out_col;
                end
            endcase
            addr = sr * w + sc;
            fin  = (out_row + 1 >= oh) && (out_col + 1 >= ow);

            beat.pixel = store[addr % STORE_DEPTH];
            beat.last  = fin;

            // The last pixel, or a position left outside a shrunken grid, rearms the engine.
            if (fin || out_row >= oh) begin
                load_count = '0;
                out_row    = '0;
                out_col    = '0;
                full       = 1'b0;
                beat.last  = 1'b1;
            end
            else begin
                next_col = out_col + 1;
                if (next_col >= ow) begin
                    out_col = '0;
                    out_row = out_row + 1'b1;
                end
                else begin
                    out_col = next_col[5:0];
                end
            end
        endfunction

        // Records a request taken by the engine.
        function void note_request(input logic kind, input logic [23:0] pix);
            bit produced;
            rotated_beat_t beat;
            advance(kind, pix, produced, beat);
            if (produced)
                owed.push_back(beat);
        endfunction

        // Compares a delivered beat with the oldest one owed.
        function void check_beat(input logic [23:0] pixel, input logic last,
                                 input logic not_ready);
            rotated_beat_t want;
            checked++;
            if (owed.size() == 0) begin
                $error("beat with none owed: pixel_out %h last_pixel %b read_status %b",
                       pixel, last, not_ready);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (pixel !== want.pixel) begin
                $error("pixel_out: expected %h, got %h", want.pixel, pixel);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_pixel: expected %b, got %b", want.last, last);
                errors++;
            end
            if (not_ready !== want.not_ready) begin
                $error("read_status: expected %b, got %b", want.not_ready, not_ready);
                errors++;
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

endpackage

// ===== bench/frame_rotate_quarter_turns_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_rotate_quarter_turns_tb
// Loads frames into the rotation engine and reads them back under every
// rotation, with random pixels, random geometry (including zero and
// over-range codes), geometry and mode changes partway through a frame,
// early reads and surplus writes. Both channels idle at random, and the
// output side holds off once long enough to back up the input. Each beat is
// checked against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module frame_rotate_quarter_turns_tb;
    import frq_pkg::*;
    import rotation_board_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int RANDOM_ITEMS  = 550;
    localparam int STEADY_TAIL   = 100;
    localparam int HOLD_AFTER    = 10;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_LIMIT   = 2000;
    localparam int TURN_TRIES    = 4;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [6:0]           cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 req_type;
    logic [23:0]          pixel_in;
    logic                 out_valid;
    logic                 out_ready;
    logic [23:0]          pixel_out;
    logic                 last_pixel;
    logic                 read_status;

    // The board follows accepted beats; the plan follows requests as they are issued.
    rotation_board board = new();
    rotation_board plan  = new();

    int send_gap_pct    = 20;
    int drain_stall_pct = 20;
    bit steady          = 1'b0;
    int issued          = 0;
    int quiet           = 0;

    frame_rotate_quarter_turns dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .pixel_in    (pixel_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_out   (pixel_out),
        .last_pixel  (last_pixel),
        .read_status (read_status)
    );

    // Clock.
    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Beat monitor on both channels.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_beat(pixel_out, last_pixel, read_status);
            if (in_valid && in_ready)
                board.note_request(req_type, pixel_in);
        end
    end

    // Watchdog on cycles with no beat moving.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // Output side: random stall bursts and one long hold-off.
    initial
    begin
        bit held;
        held = 1'b0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && board.checked >= HOLD_AFTER)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (!steady && $urandom_range(99) < drain_stall_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Offers one request and waits for its beat to be taken.
    task automatic send_request(input logic kind, input logic [23:0] pix);
        bit produced;
        rotated_beat_t unused;
        if (!(kind == REQ_WRITE && plan.full))
            issued++;
        plan.advance(kind, pix, produced, unused);
        if (!steady && $urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        pixel_in <= pix;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Waits until every owed beat has arrived and the engine has gone quiet.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] index, input logic [6:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        board.set_reg(index, value);
        plan.set_reg(index, value);
        @(posedge clk);
    endtask

    // Writes the selected registers; bit 0 mode, bit 1 height, bit 2 width.
    task automatic configure(input rot_mode_t mode, input logic [6:0] rows,
                             input logic [6:0] cols, input bit [2:0] pick);
        if (pick[0])
            put_reg(CFG_ROTATION_MODE, {5'd0, mode});
        if (pick[1])
            put_reg(CFG_IMAGE_HEIGHT, rows);
        if (pick[2])
            put_reg(CFG_IMAGE_WIDTH, cols);
        cfg_we <= 1'b0;
    endtask

    // True when the rest of the planned readout, after the given register
    // writes, reads only store entries that some earlier frame has loaded.
    function automatic bit readout_safe(input rot_mode_t mode, input logic [6:0] rows,
                                        input logic [6:0] cols, input bit [2:0] pick);
        rotation_board probe;
        bit            produced;
        rotated_beat_t beat;
        probe = plan.clone();
        if (pick[0])
            probe.set_reg(CFG_ROTATION_MODE, {5'd0, mode});
        if (pick[1])
            probe.set_reg(CFG_IMAGE_HEIGHT, rows);
        if (pick[2])
            probe.set_reg(CFG_IMAGE_WIDTH, cols);
        while (probe.full)
        begin
            probe.advance(REQ_READ, '0, produced, beat);
            if ($isunknown(beat.pixel))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // A long side: the limit itself, or anything from 16 up to the widest code.
    function automatic logic [6:0] wide_side();
        if ($urandom_range(0, 2) == 0)
            return 7'd64;
        return 7'($urandom_range(16, 127));
    endfunction

    // Mostly tiny frames; now and then one long row or column.
    function automatic void pick_geometry(output logic [6:0] rows, output logic [6:0] cols);
        case ($urandom_range(0, 9))
            0: begin
                rows = wide_side();
                cols = 7'($urandom_range(1, 2));
            end
            1: begin
                rows = 7'($urandom_range(1, 2));
                cols = wide_side();
            end
            default: begin
                rows = 7'($urandom_range(0, 6));
                cols = 7'($urandom_range(0, 6));
            end
        endcase
    endfunction

    // Reset, directed cases, random frames, drain.
    initial
    begin
        logic [23:0] px;
        logic [6:0]  rows;
        logic [6:0]  cols;
        int          n;
        int          shift_at;
        int          turn_at;
        rot_mode_t   turn_mode;
        bit [2:0]    turn_pick;
        bit          turned;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_ROTATION_MODE;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        req_type  <= REQ_WRITE;
        pixel_in  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // A read ahead of any load reports not ready.
        send_request(REQ_READ, 24'hFFFFFF);
        settle();
        configure(ROT_NONE, 7'd2, 7'd64, 3'b111);

        // A two-row frame of full width, with an early read partway through.
        for (int i = 0; i < 2 * DIM_LIMIT; i++)
        begin
            if (i == 0)
                px = '0;
            else if (i == 1)
                px = '1;
            else
                px = 24'($urandom);
            send_request(REQ_WRITE, px);
            if (i == 100)
                send_request(REQ_READ, 24'($urandom));
        end

        // A surplus write is dropped; then a partial readout, during which
        // the output side holds off.
        send_request(REQ_WRITE, 24'($urandom));
        repeat (70) send_request(REQ_READ, 24'($urandom));
        settle();

        // Shrinking to a single row leaves the read position past the grid.
        configure(ROT_NONE, 7'd1, 7'd64, 3'b110);
        send_request(REQ_READ, 24'($urandom));
        settle();

        // Zero geometry codes count as one: a single-pixel frame.
        configure(ROT_270, 7'd0, 7'd0, 3'b111);
        send_request(REQ_WRITE, 24'($urandom));
        send_request(REQ_READ, 24'($urandom));

        // Random frames.
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 2))
                0: begin
                    send_gap_pct    = 0;
                    drain_stall_pct = 0;
                end
                1: begin
                    send_gap_pct    = 15;
                    drain_stall_pct = 30;
                end
                default: begin
                    send_gap_pct    = 40;
                    drain_stall_pct = 10;
                end
            endcase
            settle();
            pick_geometry(rows, cols);
            configure(rot_mode_t'($urandom_range(0, 3)), rows, cols,
                      ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'b111);

            // Load, with stray reads and now and then a geometry change.
            shift_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : -1;
            n = 0;
            while (!plan.full)
            begin
                if (n == shift_at)
                begin
                    settle();
                    pick_geometry(rows, cols);
                    configure(rot_mode_t'($urandom_range(0, 3)), rows, cols,
                              3'($urandom_range(1, 7)));
                end
                if ($urandom_range(0, 19) == 0)
                    send_request(REQ_READ, 24'($urandom));
                else
                    send_request(REQ_WRITE, 24'($urandom));
                n++;
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) send_request(REQ_WRITE, 24'($urandom));

            // Readout, with stray writes and now and then a mode or geometry
            // change that keeps the remaining reads on loaded entries.
            turn_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : -1;
            n = 0;
            while (plan.full)
            begin
                if (n == turn_at)
                begin
                    settle();
                    turned = 1'b0;
                    for (int k = 0; k < TURN_TRIES && !turned; k++)
                    begin
                        pick_geometry(rows, cols);
                        turn_mode = rot_mode_t'($urandom_range(0, 3));
                        turn_pick = 3'($urandom_range(1, 7));
                        if (readout_safe(turn_mode, rows, cols, turn_pick))
                        begin
                            configure(turn_mode, rows, cols, turn_pick);
                            turned = 1'b1;
                        end
                    end
                end
                if ($urandom_range(0, 29) == 0)
                    send_request(REQ_WRITE, 24'($urandom));
                else
                    send_request(REQ_READ, 24'($urandom));
                n++;
            end

            if (issued >= RANDOM_ITEMS - STEADY_TAIL)
                steady = 1'b1;
        end

        // Drain and let any stray beat show up.
        settle();
        repeat (8) @(posedge clk);
        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/frq_pkg.sv
design/frq_ctrl.sv
design/frq_datapath.sv
design/frame_rotate_quarter_turns.sv
bench/rotation_board_pkg.sv
bench/frame_rotate_quarter_turns_tb.sv
